[design/xmd_pkg.sv]
// Shared types, opcode patterns and length helpers for the MOV-subset decoder.
package xmd_pkg;

  // Instruction forms
  localparam logic [2:0] FORM_RM_REG  = 3'd0;
  localparam logic [2:0] FORM_IMM_REG = 3'd1;
  localparam logic [2:0] FORM_IMM_RM  = 3'd2;
  localparam logic [2:0] FORM_MEM_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_MEM = 3'd4;

  // Record status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN   = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;
  localparam logic [1:0] STAT_ILLEGAL   = 2'd3;

  // Opcode prefixes, matched against the top bits of the byte
  localparam logic [5:0] OPC_RM_REG  = 6'b100010;
  localparam logic [3:0] OPC_IMM_REG = 4'b1011;
  localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
  localparam logic [6:0] OPC_MEM_ACC = 7'b1010000;
  localparam logic [6:0] OPC_ACC_MEM = 7'b1010001;

  // ModRM r/m code that selects a direct address under mod 00
  localparam logic [2:0] RM_DIRECT = 3'b110;
  localparam logic [1:0] MOD_REG   = 2'b11;

  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         form;
    logic               word_op;
    logic               to_register;
    logic [1:0]         mode_field;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]         length;
    logic [1:0]         status;
  } rec_t;

  // Displacement byte count for a form and ModRM byte
  function automatic logic [1:0] disp_len(input logic [2:0] form, input logic [7:0] modrm);
    logic [1:0] len;
    len = 2'd0;
    if (form == FORM_MEM_ACC || form == FORM_ACC_MEM) begin
      len = 2'd2;
    end else if (form == FORM_RM_REG || form == FORM_IMM_RM) begin
      case (modrm[7:6])
        2'b00:   len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
        2'b01:   len = 2'd1;
        2'b10:   len = 2'd2;
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

  // Immediate byte count for a form and opcode byte
  function automatic logic [1:0] imm_len(input logic [2:0] form, input logic [7:0] opcode);
    logic [1:0] len;
    len = 2'd0;
    if (form == FORM_IMM_REG) begin
      len = opcode[3] ? 2'd2 : 2'd1;
    end else if (form == FORM_IMM_RM) begin
      len = opcode[0] ? 2'd2 : 2'd1;
    end
    return len;
  endfunction

  // Sign-extend a one-byte value, pass a word, zero when absent
  function automatic logic [15:0] sext_len(input logic [15:0] v, input logic [1:0] len);
    logic [15:0] r;
    case (len)
      2'd1:    r = {{8{v[7]}}, v[7:0]};
      2'd2:    r = v;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

[design/xmd_in_reg.sv]
// Input register stage holding one stream byte ahead of the decoder.
module xmd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xmd_pkg::in_item_t in_item_i,
  output logic              item_valid_o,
  output xmd_pkg::in_item_t item_o,
  input  logic              take_i
);

  logic              valid_q, valid_d;
  xmd_pkg::in_item_t item_q;
  logic              load;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[design/xmd_decode.sv]
// Decoder state and per-byte record logic for the MOV subset.
module xmd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  xmd_pkg::in_item_t item_i,
  input  logic              space_i,
  output logic              take_o,
  output logic              rec_valid_o,
  output xmd_pkg::rec_t     rec_o
);

  logic [2:0]  pos_q, pos_d;
  logic [2:0]  need_q, need_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  form_q, form_d;

  logic [7:0]  b;
  logic [2:0]  seen_n;
  logic [1:0]  dl_q, il_q, dl_n, il_n;
  logic [2:0]  ds, is;
  logic        err;
  logic [1:0]  err_status;
  logic [2:0]  err_form;
  logic [2:0]  err_len;
  xmd_pkg::rec_t rec;
  logic        rec_valid;

  assign b      = item_i.code_byte;
  assign take_o = item_valid_i && space_i;
  assign seen_n = pos_q + 3'd1;
  assign dl_q   = xmd_pkg::disp_len(form_q, modrm_q);
  assign il_q   = xmd_pkg::imm_len(form_q, op_q);
  assign ds     = (form_q == xmd_pkg::FORM_MEM_ACC || form_q == xmd_pkg::FORM_ACC_MEM)
                  ? 3'd1 : 3'd2;
  assign is     = (form_q == xmd_pkg::FORM_IMM_REG) ? 3'd1 : 3'd2 + {1'b0, dl_q};
  assign dl_n   = xmd_pkg::disp_len(form_d, modrm_d);
  assign il_n   = xmd_pkg::imm_len(form_d, op_d);

  // Next state for the byte at the head of the input stage
  always_comb begin
    op_d       = op_q;
    modrm_d    = modrm_q;
    disp_d     = disp_q;
    imm_d      = imm_q;
    form_d     = form_q;
    need_d     = need_q;
    err        = 1'b0;
    err_status = xmd_pkg::STAT_OK;
    err_form   = xmd_pkg::FORM_RM_REG;
    err_len    = 3'd0;
    if (pos_q == 3'd0) begin
      // Opcode phase: classify and start a fresh instruction
      op_d    = b;
      modrm_d = 8'd0;
      disp_d  = 16'd0;
      imm_d   = 16'd0;
      if (b[7:2] == xmd_pkg::OPC_RM_REG) begin
        form_d = xmd_pkg::FORM_RM_REG;
      end else if (b[7:4] == xmd_pkg::OPC_IMM_REG) begin
        form_d = xmd_pkg::FORM_IMM_REG;
      end else if (b[7:1] == xmd_pkg::OPC_IMM_RM) begin
        form_d = xmd_pkg::FORM_IMM_RM;
      end else if (b[7:1] == xmd_pkg::OPC_MEM_ACC) begin
        form_d = xmd_pkg::FORM_MEM_ACC;
      end else if (b[7:1] == xmd_pkg::OPC_ACC_MEM) begin
        form_d = xmd_pkg::FORM_ACC_MEM;
      end else begin
        form_d     = xmd_pkg::FORM_RM_REG;
        err        = 1'b1;
        err_status = xmd_pkg::STAT_UNKNOWN;
        err_form   = xmd_pkg::FORM_RM_REG;
        err_len    = 3'd1;
      end
      case (form_d)
        xmd_pkg::FORM_RM_REG,
        xmd_pkg::FORM_IMM_RM:  need_d = 3'd2;
        xmd_pkg::FORM_IMM_REG: need_d = 3'd1 + {1'b0, xmd_pkg::imm_len(form_d, b)};
        default:               need_d = 3'd3;
      endcase
    end else if (pos_q == 3'd1 &&
                 (form_q == xmd_pkg::FORM_RM_REG || form_q == xmd_pkg::FORM_IMM_RM)) begin
      // ModRM phase
      modrm_d = b;
      need_d  = 3'd2 + {1'b0, xmd_pkg::disp_len(form_q, b)} + {1'b0, il_q};
      if (form_q == xmd_pkg::FORM_IMM_RM && b[7:6] == xmd_pkg::MOD_REG) begin
        err        = 1'b1;
        err_status = xmd_pkg::STAT_ILLEGAL;
        err_form   = xmd_pkg::FORM_IMM_RM;
        err_len    = 3'd2;
      end
    end else begin
      // Displacement or immediate byte, little-endian
      if (dl_q != 2'd0 && pos_q >= ds && pos_q < ds + {1'b0, dl_q}) begin
        if (pos_q == ds) begin
          disp_d[7:0] = b;
        end else begin
          disp_d[15:8] = b;
        end
      end else if (il_q != 2'd0 && pos_q >= is && pos_q < is + {1'b0, il_q}) begin
        if (pos_q == is) begin
          imm_d[7:0] = b;
        end else begin
          imm_d[15:8] = b;
        end
      end
    end
  end

  // Build the record and the next byte position
  always_comb begin
    rec       = '0;
    rec_valid = 1'b0;
    pos_d     = seen_n;
    if (err) begin
      rec_valid  = 1'b1;
      rec.form   = err_form;
      rec.length = err_len;
      rec.status = err_status;
      pos_d      = 3'd0;
    end else if (seen_n >= need_d) begin
      rec_valid         = 1'b1;
      rec.form          = form_d;
      rec.word_op       = op_d[0];
      rec.mode_field    = modrm_d[7:6];
      rec.displacement  = xmd_pkg::sext_len(disp_d, dl_n);
      rec.immediate     = xmd_pkg::sext_len(imm_d, il_n);
      rec.length        = seen_n;
      rec.status        = xmd_pkg::STAT_OK;
      case (form_d)
        xmd_pkg::FORM_RM_REG: begin
          rec.to_register    = op_d[1];
          rec.reg_field      = modrm_d[5:3];
          rec.rm_field       = modrm_d[2:0];
          rec.direct_address = (modrm_d[7:6] == 2'b00) && (modrm_d[2:0] == xmd_pkg::RM_DIRECT);
        end
        xmd_pkg::FORM_IMM_REG: begin
          rec.word_op     = op_d[3];
          rec.to_register = 1'b1;
          rec.mode_field  = xmd_pkg::MOD_REG;
          rec.reg_field   = op_d[2:0];
        end
        xmd_pkg::FORM_IMM_RM: begin
          rec.rm_field       = modrm_d[2:0];
          rec.direct_address = (modrm_d[7:6] == 2'b00) && (modrm_d[2:0] == xmd_pkg::RM_DIRECT);
        end
        default: begin
          rec.to_register    = (form_d == xmd_pkg::FORM_MEM_ACC);
          rec.mode_field     = 2'b00;
          rec.rm_field       = xmd_pkg::RM_DIRECT;
          rec.direct_address = 1'b1;
        end
      endcase
      pos_d = 3'd0;
    end else if (item_i.stream_end) begin
      rec_valid  = 1'b1;
      rec.form   = form_d;
      rec.length = seen_n;
      rec.status = xmd_pkg::STAT_TRUNCATED;
      pos_d      = 3'd0;
    end
  end

  // Advance decoder state when the byte is taken from the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      need_q  <= 3'd0;
      op_q    <= 8'd0;
      modrm_q <= 8'd0;
      disp_q  <= 16'd0;
      imm_q   <= 16'd0;
      form_q  <= 3'd0;
    end else if (take_o) begin
      pos_q   <= pos_d;
      need_q  <= need_d;
      op_q    <= op_d;
      modrm_q <= modrm_d;
      disp_q  <= disp_d;
      imm_q   <= imm_d;
      form_q  <= form_d;
    end
  end

  assign rec_valid_o = rec_valid;
  assign rec_o       = rec;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 3'd5)
    else $error("byte position past the longest instruction");
  a_rec_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && rec_valid |-> rec.length != 3'd0)
    else $error("record with zero length");
  a_rec_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && rec_valid |=> pos_q == 3'd0)
    else $error("decoder not back in opcode phase after a record");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && rec_valid && rec.status != xmd_pkg::STAT_OK
    |-> rec.displacement == 16'sd0 && rec.immediate == 16'sd0)
    else $error("error record carries operand data");
`endif

endmodule

[design/xmd_out_reg.sv]
// Result register that holds one decoded record for the output stream.
module xmd_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  xmd_pkg::rec_t                      rec_i,
  output logic                               space_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [xmd_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [xmd_pkg::OUT_USER_W-1:0]     out_user_o
);

  logic          valid_q, valid_d;
  xmd_pkg::rec_t rec_q;

  // Room when empty or when the held record leaves this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  // Pack fields from the lowest bit up, zero pad to whole bytes
  assign out_data_o = {7'd0,
                       rec_q.length,
                       rec_q.immediate,
                       rec_q.displacement,
                       rec_q.direct_address,
                       rec_q.rm_field,
                       rec_q.reg_field,
                       rec_q.mode_field,
                       rec_q.to_register,
                       rec_q.word_op,
                       rec_q.form};
  assign out_user_o  = rec_q.status;
  assign out_valid_o = valid_q;

endmodule

[design/x86_16_mov_decoder_top.sv]
// MOV-subset 16-bit x86 decoder: one stream byte in, one decoded record per instruction.
// Bytes pass the input register; a completed record is held in the result register.
// Throughput: one byte per cycle; the decoder state updates in one pass per byte.
// Back-pressure on the output stalls input only once both stage registers are full.
// Reset (rst_ni low, asynchronous) empties both stages and returns to the opcode phase.
module x86_16_mov_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] form, [3] word_op, [4] to_register, [6:5] mode_field, [9:7] reg_field,
  // [12:10] rm_field, [13] direct_address, [29:14] displacement,
  // [45:30] immediate, [48:46] length, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  xmd_pkg::in_item_t in_item;
  xmd_pkg::in_item_t item;
  xmd_pkg::rec_t     rec;
  logic              item_valid;
  logic              take;
  logic              space;
  logic              rec_valid;

  assign in_item.code_byte  = s_axis_tdata;
  assign in_item.stream_end = s_axis_tlast;

  xmd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  xmd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .space_i      (space),
    .take_o       (take),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec)
  );

  xmd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && rec_valid),
    .rec_i       (rec),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

[tb/sv/tb_x86_16_mov_decoder_top.sv]
// Self-checking testbench for the MOV-subset x86 decoder: directed table, then random streams.
`timescale 1ns / 100ps

module tb_x86_16_mov_decoder_top;

  localparam int unsigned RAND_BYTES     = 700;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AT_BYTE   = 350;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One row of the directed stream; error records are typed in, others are predicted
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    logic [2:0] form;
    logic [2:0] length;
    logic [1:0] status;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // unknown opcodes at both ends of the byte range, first one right after reset
    '{8'h00, 1'b0, 1'b1, xmd_pkg::FORM_RM_REG, 3'd1, xmd_pkg::STAT_UNKNOWN},
    '{8'hFF, 1'b0, 1'b1, xmd_pkg::FORM_RM_REG, 3'd1, xmd_pkg::STAT_UNKNOWN},
    // rm-reg, register operand
    '{8'h89, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'hD8, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // rm-reg, negative byte displacement
    '{8'h8A, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h47, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h80, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // imm-rm to a direct address with a word immediate: six bytes
    '{8'hC7, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h06, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h34, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h12, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h00, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h80, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // imm-rm with a register operand is illegal
    '{8'hC6, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'hC0, 1'b0, 1'b1, xmd_pkg::FORM_IMM_RM, 3'd2, xmd_pkg::STAT_ILLEGAL},
    // imm-reg, byte immediate of all ones
    '{8'hB0, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'hFF, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // mem-acc with the largest positive address
    '{8'hA1, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'hFF, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h7F, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // acc-mem with the most negative address
    '{8'hA2, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h00, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h80, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    // stream ends right after an opcode
    '{8'h8B, 1'b1, 1'b1, xmd_pkg::FORM_RM_REG, 3'd1, xmd_pkg::STAT_TRUNCATED},
    // stream ends inside a displacement
    '{8'hC6, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h85, 1'b0, 1'b0, xmd_pkg::FORM_RM_REG, 3'd0, xmd_pkg::STAT_OK},
    '{8'h12, 1'b1, 1'b1, xmd_pkg::FORM_IMM_RM, 3'd3, xmd_pkg::STAT_TRUNCATED}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Decoder state mirrored by the predictor
  logic [2:0]  dec_pos;
  logic [2:0]  dec_need;
  logic [7:0]  dec_op;
  logic [7:0]  dec_modrm;
  logic [15:0] dec_disp;
  logic [15:0] dec_imm;
  logic [2:0]  dec_form;

  xmd_pkg::rec_t pending_recs[$];
  int unsigned errors         = 0;
  int unsigned bytes_sent     = 0;
  int unsigned records_seen   = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned burst_left     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned long_holds     = 0;
  bit          want_long_hold = 1'b0;

  x86_16_mov_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Displacement bytes that follow the opcode or ModRM byte
  function automatic int unsigned addr_bytes(input logic [2:0] f, input logic [7:0] mrm);
    if (f == xmd_pkg::FORM_MEM_ACC || f == xmd_pkg::FORM_ACC_MEM) return 2;
    if (f == xmd_pkg::FORM_IMM_REG) return 0;
    if (mrm[7:6] == 2'b01) return 1;
    if (mrm[7:6] == 2'b10) return 2;
    return (mrm[7:6] == 2'b00 && mrm[2:0] == xmd_pkg::RM_DIRECT) ? 2 : 0;
  endfunction

  // Immediate bytes at the tail of the instruction
  function automatic int unsigned data_bytes(input logic [2:0] f, input logic [7:0] op);
    if (f == xmd_pkg::FORM_IMM_REG) return op[3] ? 2 : 1;
    if (f == xmd_pkg::FORM_IMM_RM) return op[0] ? 2 : 1;
    return 0;
  endfunction

  // Widen a collected value: sign-extend one byte, keep a word, zero when absent
  function automatic logic [15:0] widen(input logic [15:0] v, input int unsigned n);
    if (n == 0) return 16'h0000;
    if (n == 1) return {{8{v[7]}}, v[7:0]};
    return v;
  endfunction

  function automatic string rec_str(input xmd_pkg::rec_t r);
    return $sformatf({"form=%0d w=%0d d=%0d mod=%0d reg=%0d rm=%0d da=%0d",
                      " disp=%0d imm=%0d len=%0d st=%0d"},
                     r.form, r.word_op, r.to_register, r.mode_field, r.reg_field, r.rm_field,
                     r.direct_address, r.displacement, r.immediate, r.length, r.status);
  endfunction

  task automatic clear_decoder();
    dec_pos   = 3'd0;
    dec_need  = 3'd0;
    dec_op    = 8'h00;
    dec_modrm = 8'h00;
    dec_disp  = 16'h0000;
    dec_imm   = 16'h0000;
    dec_form  = xmd_pkg::FORM_RM_REG;
  endtask

  // Advance the mirrored decoder by one byte; has is set when a record comes out
  task automatic decode_byte(input logic [7:0] b, input logic last, output bit has,
                             output xmd_pkg::rec_t r);
    int unsigned pos;
    int unsigned dl;
    int unsigned il;
    int unsigned ds;
    int unsigned ist;
    bit          done;
    has  = 1'b0;
    done = 1'b0;
    r    = '0;
    pos  = dec_pos;
    if (pos == 0) begin
      clear_decoder();
      dec_op = b;
      if (b[7:2] == xmd_pkg::OPC_RM_REG) dec_form = xmd_pkg::FORM_RM_REG;
      else if (b[7:4] == xmd_pkg::OPC_IMM_REG) dec_form = xmd_pkg::FORM_IMM_REG;
      else if (b[7:1] == xmd_pkg::OPC_IMM_RM) dec_form = xmd_pkg::FORM_IMM_RM;
      else if (b[7:1] == xmd_pkg::OPC_MEM_ACC) dec_form = xmd_pkg::FORM_MEM_ACC;
      else if (b[7:1] == xmd_pkg::OPC_ACC_MEM) dec_form = xmd_pkg::FORM_ACC_MEM;
      else begin
        r.form   = xmd_pkg::FORM_RM_REG;
        r.length = 3'd1;
        r.status = xmd_pkg::STAT_UNKNOWN;
        done     = 1'b1;
      end
      if (dec_form == xmd_pkg::FORM_RM_REG || dec_form == xmd_pkg::FORM_IMM_RM)
        dec_need = 3'd2;
      else if (dec_form == xmd_pkg::FORM_IMM_REG)
        dec_need = 3'(1 + data_bytes(dec_form, dec_op));
      else dec_need = 3'd3;
    end else if (pos == 1 && (dec_form == xmd_pkg::FORM_RM_REG ||
                              dec_form == xmd_pkg::FORM_IMM_RM)) begin
      dec_modrm = b;
      if (dec_form == xmd_pkg::FORM_IMM_RM && b[7:6] == xmd_pkg::MOD_REG) begin
        r.form   = xmd_pkg::FORM_IMM_RM;
        r.length = 3'd2;
        r.status = xmd_pkg::STAT_ILLEGAL;
        done     = 1'b1;
      end
      dec_need = 3'(2 + addr_bytes(dec_form, b) + data_bytes(dec_form, dec_op));
    end else begin
      // place the byte in the displacement or the immediate, little-endian
      dl  = addr_bytes(dec_form, dec_modrm);
      il  = data_bytes(dec_form, dec_op);
      ds  = (dec_form == xmd_pkg::FORM_MEM_ACC || dec_form == xmd_pkg::FORM_ACC_MEM) ? 1 : 2;
      ist = (dec_form == xmd_pkg::FORM_IMM_REG) ? 1 : 2 + dl;
      if (dl != 0 && pos >= ds && pos < ds + dl)
        dec_disp = dec_disp | ({8'h00, b} << (8 * (pos - ds)));
      else if (il != 0 && pos >= ist && pos < ist + il)
        dec_imm = dec_imm | ({8'h00, b} << (8 * (pos - ist)));
    end

    if (done) begin
      has = 1'b1;
      clear_decoder();
    end else begin
      dec_pos = 3'(pos + 1);
      if (dec_pos >= dec_need) begin
        dl = addr_bytes(dec_form, dec_modrm);
        il = data_bytes(dec_form, dec_op);
        r.form         = dec_form;
        r.length       = dec_pos;
        r.status       = xmd_pkg::STAT_OK;
        r.displacement = widen(dec_disp, dl);
        r.immediate    = widen(dec_imm, il);
        r.word_op      = dec_op[0];
        case (dec_form)
          xmd_pkg::FORM_RM_REG, xmd_pkg::FORM_IMM_RM: begin
            r.to_register    = (dec_form == xmd_pkg::FORM_RM_REG) ? dec_op[1] : 1'b0;
            r.mode_field     = dec_modrm[7:6];
            r.reg_field      = (dec_form == xmd_pkg::FORM_RM_REG) ? dec_modrm[5:3] : 3'd0;
            r.rm_field       = dec_modrm[2:0];
            r.direct_address = (dec_modrm[7:6] == 2'b00 &&
                                dec_modrm[2:0] == xmd_pkg::RM_DIRECT);
          end
          xmd_pkg::FORM_IMM_REG: begin
            r.word_op     = dec_op[3];
            r.to_register = 1'b1;
            r.mode_field  = xmd_pkg::MOD_REG;
            r.reg_field   = dec_op[2:0];
          end
          default: begin
            r.to_register    = (dec_form == xmd_pkg::FORM_MEM_ACC);
            r.rm_field       = xmd_pkg::RM_DIRECT;
            r.direct_address = 1'b1;
          end
        endcase
        has = 1'b1;
        clear_decoder();
      end else if (last) begin
        r.form   = dec_form;
        r.length = dec_pos;
        r.status = xmd_pkg::STAT_TRUNCATED;
        has      = 1'b1;
        clear_decoder();
      end
    end
  endtask

  // Offer one item in bursts with random gaps, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input xmd_pkg::rec_t typed_rec);
    int unsigned   gap;
    bit            has;
    xmd_pkg::rec_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ((bytes_sent / 128) % 2 == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    decode_byte(b, last, has, r);
    if (typed) pending_recs.push_back(typed_rec);
    else if (has) pending_recs.push_back(r);
  endtask

  task automatic flag_bad(input string what, input xmd_pkg::rec_t want,
                          input xmd_pkg::rec_t got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t mismatch, %s: expected %s / got %s", $time, what, rec_str(want),
               rec_str(got));
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin : rx_pattern
    int unsigned tick;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
        long_holds++;
      end else begin
        tick++;
        case ((tick / 100) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ((tick % 5) != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  // Check each accepted record against the oldest pending one
  always @(posedge clk_i) begin : record_check
    xmd_pkg::rec_t got;
    xmd_pkg::rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got                = '0;
      got.form           = m_axis_tdata[2:0];
      got.word_op        = m_axis_tdata[3];
      got.to_register    = m_axis_tdata[4];
      got.mode_field     = m_axis_tdata[6:5];
      got.reg_field      = m_axis_tdata[9:7];
      got.rm_field       = m_axis_tdata[12:10];
      got.direct_address = m_axis_tdata[13];
      got.displacement   = m_axis_tdata[29:14];
      got.immediate      = m_axis_tdata[45:30];
      got.length         = m_axis_tdata[48:46];
      got.status         = m_axis_tuser;
      records_seen++;
      if (pending_recs.size() == 0) begin
        flag_bad("record with nothing pending", '0, got);
      end else begin
        want = pending_recs.pop_front();
        status_seen[want.status]++;
        if (got.form != want.form || got.word_op != want.word_op ||
            got.to_register != want.to_register || got.mode_field != want.mode_field ||
            got.reg_field != want.reg_field || got.rm_field != want.rm_field ||
            got.direct_address != want.direct_address ||
            got.displacement != want.displacement || got.immediate != want.immediate ||
            got.length != want.length || got.status != want.status)
          flag_bad("field differs", want, got);
        else if (m_axis_tdata[55:49] != '0)
          flag_bad("padding bits set", want, got);
      end
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles, %0d records pending", $time,
                 quiet_cycles, pending_recs.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    xmd_pkg::rec_t typed_rec;
    logic [7:0]    pkt[$];
    logic [7:0]    op;
    logic [7:0]    mrm;
    logic [2:0]    f;
    int unsigned   pick;
    int unsigned   total;
    int unsigned   keep;
    bit            end_on_last;
    bit            hold_asked;
    hold_asked = 1'b0;
    clear_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_rec        = '0;
      typed_rec.form   = DIR_TAB[i].form;
      typed_rec.length = DIR_TAB[i].length;
      typed_rec.status = DIR_TAB[i].status;
      send_byte(DIR_TAB[i].code, DIR_TAB[i].last, DIR_TAB[i].typed, typed_rec);
    end

    // random streams: mostly whole instructions, some cut short, some noise bytes
    while (bytes_sent < DIR_ROWS + RAND_BYTES) begin
      if (!hold_asked && bytes_sent >= HOLD_AT_BYTE) begin
        hold_asked     = 1'b1;
        want_long_hold = 1'b1;
      end
      pkt.delete();
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        pkt.push_back(8'($urandom));
        end_on_last = $urandom_range(0, 1);
      end else begin
        f  = 3'($urandom_range(0, 4));
        op = 8'($urandom);
        case (f)
          xmd_pkg::FORM_RM_REG:  op[7:2] = xmd_pkg::OPC_RM_REG;
          xmd_pkg::FORM_IMM_REG: op[7:4] = xmd_pkg::OPC_IMM_REG;
          xmd_pkg::FORM_IMM_RM:  op[7:1] = xmd_pkg::OPC_IMM_RM;
          xmd_pkg::FORM_MEM_ACC: op[7:1] = xmd_pkg::OPC_MEM_ACC;
          default:               op[7:1] = xmd_pkg::OPC_ACC_MEM;
        endcase
        pkt.push_back(op);
        mrm = 8'($urandom);
        if (f == xmd_pkg::FORM_IMM_RM && mrm[7:6] == xmd_pkg::MOD_REG &&
            $urandom_range(0, 7) != 0)
          mrm[7:6] = 2'($urandom_range(0, 2));
        if (f == xmd_pkg::FORM_RM_REG || f == xmd_pkg::FORM_IMM_RM) pkt.push_back(mrm);
        if (f == xmd_pkg::FORM_IMM_RM && mrm[7:6] == xmd_pkg::MOD_REG) total = 2;
        else total = pkt.size() + addr_bytes(f, mrm) + data_bytes(f, op);
        while (pkt.size() < total) pkt.push_back(8'($urandom));
        if (pick == 8 && total > 1) begin
          keep = $urandom_range(1, total - 1);
          while (pkt.size() > keep) void'(pkt.pop_back());
          end_on_last = 1'b1;
        end else begin
          end_on_last = ($urandom_range(0, 7) == 0);
        end
      end
      for (int i = 0; i < pkt.size(); i++)
        send_byte(pkt[i], end_on_last && (i == pkt.size() - 1), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the pipeline time to show any stray record
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Decoded %0d bytes into %0d records: %0d ok, %0d unknown opcode, %0d truncated,",
             bytes_sent, records_seen, status_seen[xmd_pkg::STAT_OK],
             status_seen[xmd_pkg::STAT_UNKNOWN], status_seen[xmd_pkg::STAT_TRUNCATED]);
    $display("%0d illegal mode; %0d long output hold-offs; %0d mismatches.",
             status_seen[xmd_pkg::STAT_ILLEGAL], long_holds, errors);
    if (errors == 0 && pending_recs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[x86_16_mov_decoder_top.f]
design/xmd_pkg.sv
design/xmd_in_reg.sv
design/xmd_decode.sv
design/xmd_out_reg.sv
design/x86_16_mov_decoder_top.sv
tb/sv/tb_x86_16_mov_decoder_top.sv
